// ===== hdl/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg
// Item types, calendar constants and small date helper functions for the
// calendar clock tick block.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [13:0] YEAR_MAX   = 14'd16383;
  localparam logic [13:0] YEAR_DFLT  = 14'd1000;

  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_APR  = 4'd4;
  localparam logic [3:0]  MONTH_JUN  = 4'd6;
  localparam logic [3:0]  MONTH_SEP  = 4'd9;
  localparam logic [3:0]  MONTH_NOV  = 4'd11;

  localparam logic [5:0]  RST_SECOND = 6'd0;
  localparam logic [5:0]  RST_MINUTE = 6'd0;
  localparam logic [4:0]  RST_HOUR   = 5'd0;
  localparam logic [4:0]  RST_DAY    = 5'd1;
  localparam logic [3:0]  RST_MONTH  = 4'd1;
  localparam logic [13:0] RST_YEAR   = 14'd1970;

  // reciprocal of 25 scaled by 2^17, exact floor for 14-bit years
  localparam logic [12:0] RECIP_25   = 13'd5243;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [5:0]  set_second;
    logic [5:0]  set_minute;
    logic [4:0]  set_hour;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [13:0] set_year;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
  } out_item_t;

  // gregorian leap year: by 4 and not by 100, or by 400
  function automatic logic is_leap(input logic [13:0] year);
    logic [26:0] prod;
    logic [9:0]  quo;
    logic [14:0] back;
    logic        by25;
    prod = year * RECIP_25;
    quo  = prod[26:17];
    back = {1'b0, quo, 4'b0000} + {2'b00, quo, 3'b000} + {5'b00000, quo};
    by25 = (back == {1'b0, year});
    return (year[1:0] == 2'b00) && (!by25 || (year[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    if (month == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if ((month == MONTH_APR) || (month == MONTH_JUN) ||
                 (month == MONTH_SEP) || (month == MONTH_NOV)) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ===== hdl/calendar_clock_tick_top.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_tick_top
// Time-of-day and calendar counter with tick and checked-load items.
// ----------------------------------------------------------------------------
// usage:
//   in channel  : in_valid / in_ready / in_item, one item per tick or load
//   out channel : out_valid / out_ready / out_item, one result per item, the
//                 time and date after that item
//   an accepted item is captured in an input register; when the output
//   register is free the step logic updates the counters and writes the
//   output register, which raises out_valid and holds the result until
//   out_ready takes it
//   throughput is one item per cycle while out_ready stays high; the single
//   step stage between the input register and the counters sets that figure
//   while the receiver stalls the output register holds its result, and one
//   more item is taken into the input register; after that in_ready drops
//   until out_ready returns
//   synchronous reset (rst_n low) empties both registers and loads the
//   counters with 00:00:00 on 1 January 1970
// ----------------------------------------------------------------------------
module calendar_clock_tick_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cct_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cct_pkg::out_item_t out_item
);
  import cct_pkg::*;

  // input register
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_item_r;

  // counters, the live time and date
  out_item_t cnt_r;
  out_item_t cnt_nxt;

  // output register
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;

  logic      out_free;
  logic      step_en;
  logic      in_take;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  // the input register item moves through the step logic when it has room
  assign step_en  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !out_free);
  assign out_valid_nxt = step_en || (out_valid_r && !out_ready);

  cct_step u_step (
    .cur  (cnt_r),
    .item (s1_item_r),
    .nxt  (cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      cnt_r.cur_second <= RST_SECOND;
      cnt_r.cur_minute <= RST_MINUTE;
      cnt_r.cur_hour   <= RST_HOUR;
      cnt_r.cur_day    <= RST_DAY;
      cnt_r.cur_month  <= RST_MONTH;
      cnt_r.cur_year   <= RST_YEAR;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step_en) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (step_en) begin
      out_item_r <= cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a result always carries in-range time and date fields
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.cur_second <= SEC_LAST) &&
                    (out_item_r.cur_minute <= MIN_LAST) &&
                    (out_item_r.cur_hour <= HOUR_LAST))
    else $error("result time field out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.cur_day != 5'd0) &&
                    (out_item_r.cur_month != 4'd0) &&
                    (out_item_r.cur_month <= MONTH_LAST) &&
                    (out_item_r.cur_year != 14'd0))
    else $error("result date field out of range");

  // a step always lands in the output register
  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r && (out_item_r == cnt_r))
    else $error("stepped item missing from output register");

  // counters change only when an item is stepped
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(cnt_r))
    else $error("counters moved without an item");

  // a held input item is never overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost a waiting item");

endmodule

// ===== hdl/cct_step.sv =====
// ----------------------------------------------------------------------------
// cct_step
// Next time and date for one item: one-second advance with carries, or a
// checked load of all fields.
// ----------------------------------------------------------------------------
module cct_step (
  input  cct_pkg::out_item_t cur,
  input  cct_pkg::in_item_t  item,
  output cct_pkg::out_item_t nxt
);
  import cct_pkg::*;

  out_item_t  tick_v;
  out_item_t  load_v;
  logic [4:0] tick_len;
  logic [4:0] load_len;
  logic [13:0] load_year;
  logic [3:0]  load_month;

  // tick path
  always_comb begin
    tick_len = month_len(cur.cur_month, is_leap(cur.cur_year));
    tick_v   = cur;
    if (cur.cur_second < SEC_LAST) begin
      tick_v.cur_second = cur.cur_second + 6'd1;
    end else begin
      tick_v.cur_second = 6'd0;
      if (cur.cur_minute < MIN_LAST) begin
        tick_v.cur_minute = cur.cur_minute + 6'd1;
      end else begin
        tick_v.cur_minute = 6'd0;
        if (cur.cur_hour < HOUR_LAST) begin
          tick_v.cur_hour = cur.cur_hour + 5'd1;
        end else begin
          tick_v.cur_hour = 5'd0;
          if (cur.cur_day < tick_len) begin
            tick_v.cur_day = cur.cur_day + 5'd1;
          end else begin
            tick_v.cur_day = 5'd1;
            if (cur.cur_month < MONTH_LAST) begin
              tick_v.cur_month = cur.cur_month + 4'd1;
            end else begin
              tick_v.cur_month = 4'd1;
              if (cur.cur_year < YEAR_MAX) begin
                tick_v.cur_year = cur.cur_year + 14'd1;
              end
            end
          end
        end
      end
    end
  end

  // load path, day checked against the already-corrected month and year
  always_comb begin
    load_year  = (item.set_year != 14'd0) ? item.set_year : YEAR_DFLT;
    load_month = ((item.set_month >= 4'd1) && (item.set_month <= MONTH_LAST)) ?
                 item.set_month : 4'd1;
    load_len   = month_len(load_month, is_leap(load_year));
    load_v.cur_second = (item.set_second <= SEC_LAST) ? item.set_second : 6'd0;
    load_v.cur_minute = (item.set_minute <= MIN_LAST) ? item.set_minute : 6'd0;
    load_v.cur_hour   = (item.set_hour <= HOUR_LAST) ? item.set_hour : 5'd0;
    load_v.cur_month  = load_month;
    load_v.cur_year   = load_year;
    load_v.cur_day    = ((item.set_day >= 5'd1) && (item.set_day <= load_len)) ?
                        item.set_day : 5'd1;
  end

  always_comb begin
    unique case (item.cmd)
      CMD_LOAD: nxt = load_v;
      CMD_TICK: nxt = tick_v;
      default:  nxt = tick_v;
    endcase
  end

endmodule
